// File: rtl/bid_pkg.sv
// Shared widths, constants and the divider stage word for the box IoU distance block.
// Used by bid_div_stage, box_iou_distance and the bench files; depends on nothing else.
package bid_pkg;

  localparam int COORD_BITS      = 12;
  localparam int FRAC_BITS       = 16;
  localparam int SUM_W           = COORD_BITS + 1;
  localparam int AREA_W          = 2 * COORD_BITS;
  localparam int UNI_W           = AREA_W + 1;
  localparam int DIST_W          = FRAC_BITS + 1;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int QUO_W           = DIV_STAGES * STEPS_PER_STAGE;
  localparam int FRONT_STAGES    = 4;
  localparam int NUM_STAGES      = FRONT_STAGES + DIV_STAGES + 1;
  localparam int IN_W            = 8 * COORD_BITS;
  localparam int IN_TDATA_W      = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = ((DIST_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [UNI_W-1:0] rem;
    logic [UNI_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             sep;
    logic             zero;
    logic             full;
  } bid_div_t;

endpackage

// File: rtl/bid_div_stage.sv
// One registered stage of the restoring divider: two quotient bits per stage.
// Depends on bid_pkg for widths and the stage word.
module bid_div_stage (
  input  logic              clk_i,
  input  logic              en_i,
  input  bid_pkg::bid_div_t data_i,
  output bid_pkg::bid_div_t data_o
);
  import bid_pkg::*;

  bid_div_t data_d;
  bid_div_t data_q;

  always_comb begin
    logic [UNI_W:0]   r2;
    logic [UNI_W-1:0] r;
    logic [QUO_W-1:0] q;
    r = data_i.rem;
    q = data_i.quo;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, data_i.den}) begin
        r = UNI_W'(r2 - {1'b0, data_i.den});
        q = {q[QUO_W-2:0], 1'b1};
      end else begin
        r = r2[UNI_W-1:0];
        q = {q[QUO_W-2:0], 1'b0};
      end
    end
    data_d      = data_i;
    data_d.rem  = r;
    data_d.quo  = q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/box_iou_distance.sv
// Top level of the box IoU distance block: front stages, divider chain, output stage.
// Depends on bid_pkg and bid_div_stage.
//
// Takes one box pair per word and returns 1 - IoU in unsigned Q1.16 (65536 = 1.0), with a
// no-overlap flag on tuser. A new word is accepted every cycle while tready is high; each
// result passes through four front stages for edges, areas and intersection, eight divider
// stages at two quotient bits each, one output stage. Every stage holds while the stage after
// it is full and stalled, so back-pressure fills bubbles before it reaches the input.
module box_iou_distance (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height
  input  logic [bid_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // distance, zero pad
  output logic [bid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // no_overlap
  output logic                             m_axis_tuser
);
  import bid_pkg::*;

  localparam int CW = COORD_BITS;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = ~vld_q[NUM_STAGES-1] | m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // stage 1: unpack, right and bottom edges
  logic [CW-1:0]    ax_q, ay_q, aw_q, ah_q, bx_q, by_q, bw_q, bh_q;
  logic [SUM_W-1:0] ar_q, ab_q, br_q, bb_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax_q <= s_axis_tdata[0*CW +: CW];
      ay_q <= s_axis_tdata[1*CW +: CW];
      aw_q <= s_axis_tdata[2*CW +: CW];
      ah_q <= s_axis_tdata[3*CW +: CW];
      bx_q <= s_axis_tdata[4*CW +: CW];
      by_q <= s_axis_tdata[5*CW +: CW];
      bw_q <= s_axis_tdata[6*CW +: CW];
      bh_q <= s_axis_tdata[7*CW +: CW];
      ar_q <= SUM_W'(s_axis_tdata[0*CW +: CW]) + SUM_W'(s_axis_tdata[2*CW +: CW]);
      ab_q <= SUM_W'(s_axis_tdata[1*CW +: CW]) + SUM_W'(s_axis_tdata[3*CW +: CW]);
      br_q <= SUM_W'(s_axis_tdata[4*CW +: CW]) + SUM_W'(s_axis_tdata[6*CW +: CW]);
      bb_q <= SUM_W'(s_axis_tdata[5*CW +: CW]) + SUM_W'(s_axis_tdata[7*CW +: CW]);
    end
  end

  // stage 2: separation test, overlap extents, box areas
  logic              sep2_q;
  logic [CW-1:0]     cols_q, rows_q;
  logic [AREA_W-1:0] area_a_q, area_b_q;
  logic [SUM_W-1:0]  rmin, bmin, lmax, tmax;

  always_comb begin
    rmin = (ar_q < br_q) ? ar_q : br_q;
    bmin = (ab_q < bb_q) ? ab_q : bb_q;
    lmax = (ax_q > bx_q) ? SUM_W'(ax_q) : SUM_W'(bx_q);
    tmax = (ay_q > by_q) ? SUM_W'(ay_q) : SUM_W'(by_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sep2_q   <= (SUM_W'(ax_q) > br_q) | (SUM_W'(ay_q) > bb_q) |
                  (ar_q < SUM_W'(bx_q)) | (ab_q < SUM_W'(by_q));
      cols_q   <= CW'(rmin - lmax);
      rows_q   <= CW'(bmin - tmax);
      area_a_q <= AREA_W'(aw_q) * AREA_W'(ah_q);
      area_b_q <= AREA_W'(bw_q) * AREA_W'(bh_q);
    end
  end

  // stage 3: intersection area, sum of areas
  logic              sep3_q;
  logic [AREA_W-1:0] inter_q;
  logic [UNI_W-1:0]  asum_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sep3_q  <= sep2_q;
      inter_q <= AREA_W'(cols_q) * AREA_W'(rows_q);
      asum_q  <= UNI_W'(area_a_q) + UNI_W'(area_b_q);
    end
  end

  // stage 4: union and special cases, divider entry
  bid_div_t div_in_q;
  bid_div_t div_chain [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      div_in_q.rem  <= UNI_W'(inter_q);
      div_in_q.den  <= asum_q - UNI_W'(inter_q);
      div_in_q.quo  <= '0;
      div_in_q.sep  <= sep3_q;
      div_in_q.zero <= (asum_q == UNI_W'(inter_q));
      div_in_q.full <= (asum_q == {inter_q, 1'b0});
    end
  end

  assign div_chain[0] = div_in_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bid_div_stage u_stage (
      .clk_i  (clk_i),
      .en_i   (en[FRONT_STAGES + g]),
      .data_i (div_chain[g]),
      .data_o (div_chain[g+1])
    );
  end

  // output stage
  logic [DIST_W-1:0] dist_d, dist_q;
  logic              flag_d, flag_q;
  bid_div_t          last;

  always_comb begin
    last = div_chain[DIV_STAGES];
    if (last.sep | last.zero) begin
      dist_d = ONE_Q;
      flag_d = 1'b1;
    end else if (last.full) begin
      dist_d = '0;
      flag_d = 1'b0;
    end else begin
      dist_d = ONE_Q - {1'b0, last.quo[QUO_W-1 -: FRAC_BITS]};
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      dist_q <= dist_d;
      flag_q <= flag_d;
    end
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = OUT_TDATA_W'(dist_q);
  assign m_axis_tuser  = flag_q;

endmodule

// File: bench/box_iou_checker.sv
`timescale 1ns / 1ps
// Checker for box_iou_distance: watches both stream channels, predicts 1 - IoU for each
// accepted box pair and compares it with the words coming out. Depends on bid_pkg.
module box_iou_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [bid_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [bid_pkg::OUT_TDATA_W-1:0] out_data_i,
  input  logic                            out_flag_i,
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              checked_o,
  output int                              apart_o
);
  import bid_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              no_overlap;
  } iou_t;

  iou_t iou_expected_q[$];
  int   mismatch_count;
  int   checked_count;
  int   apart_count;

  function automatic iou_t predict_iou(input logic [IN_TDATA_W-1:0] word);
    longint unsigned c[8];
    longint unsigned one_q;
    longint unsigned a_right, a_bottom, b_right, b_bottom;
    longint unsigned cols, rows, overlap, union_area, ratio;
    iou_t r;
    one_q = longint'(1) << FRAC_BITS;
    for (int i = 0; i < 8; i++) c[i] = word[i*COORD_BITS +: COORD_BITS];
    a_right  = c[0] + c[2];
    a_bottom = c[1] + c[3];
    b_right  = c[4] + c[6];
    b_bottom = c[5] + c[7];
    r.distance   = one_q[DIST_W-1:0];
    r.no_overlap = 1'b1;
    if (c[0] > b_right || c[1] > b_bottom || a_right < c[4] || a_bottom < c[5]) return r;
    cols = ((a_right < b_right) ? a_right : b_right) - ((c[0] > c[4]) ? c[0] : c[4]);
    rows = ((a_bottom < b_bottom) ? a_bottom : b_bottom) - ((c[1] > c[5]) ? c[1] : c[5]);
    overlap    = cols * rows;
    union_area = c[2] * c[3] + c[6] * c[7] - overlap;
    if (union_area == 0) return r;
    ratio = (overlap << FRAC_BITS) / union_area;
    if (ratio > one_q) ratio = one_q;
    r.distance   = DIST_W'(one_q - ratio);
    r.no_overlap = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    iou_t want;
    if (!rst_ni) begin
      iou_expected_q.delete();
      mismatch_count = 0;
      checked_count  = 0;
      apart_count    = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      apart_o       <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        iou_expected_q.insert(iou_expected_q.size(), predict_iou(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (iou_expected_q.size() == 0) begin
          $error("result word with nothing expected: distance %0d, no_overlap %0b",
                 out_data_i[DIST_W-1:0], out_flag_i);
          mismatch_count++;
        end else begin
          want = iou_expected_q.pop_front();
          checked_count++;
          if (out_flag_i) apart_count++;
          if (out_data_i[DIST_W-1:0] !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_data_i[DIST_W-1:0]);
            mismatch_count++;
          end
          if (out_flag_i !== want.no_overlap) begin
            $error("no_overlap: expected %0b, got %0b", want.no_overlap, out_flag_i);
            mismatch_count++;
          end
          if (out_data_i[OUT_TDATA_W-1:DIST_W] !== '0) begin
            $error("pad: expected 0, got %0h", out_data_i[OUT_TDATA_W-1:DIST_W]);
            mismatch_count++;
          end
        end
      end
      mismatches_o <= mismatch_count;
      pending_o    <= iou_expected_q.size();
      checked_o    <= checked_count;
      apart_o      <= apart_count;
    end
  end

endmodule

// File: bench/tb_box_iou_distance.sv
`timescale 1ns / 1ps
// Testbench top for box_iou_distance: clock, reset, box pair stimulus, result sink and verdict.
// Depends on bid_pkg, box_iou_checker and the block itself.
module tb_box_iou_distance;
  import bid_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int N_RANDOM    = 500;
  localparam int CALM_ITEMS  = 80;
  localparam int HOLD_FROM   = 150;
  localparam int HOLD_ITEMS  = 40;
  localparam int DRAIN_AT    = 300;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int mismatches, pending, checked, apart;
  int pairs_sent   = 0;
  int cycle_count  = 0;
  bit hold_request = 1'b0;
  bit calm         = 1'b0;

  always #5 clk_i = ~clk_i;

  box_iou_distance dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  box_iou_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_flag_i   (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .apart_o      (apart)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result sink: random stalls, one long hold on request
  initial begin : sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic coord_t to_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_boxes(input coord_t al, at, aw, ah, bl, bt, bw, bh, input bit gap_ok);
    s_axis_tdata  <= IN_TDATA_W'({bh, bw, bt, bl, ah, aw, at, al});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
    if (gap_ok && !calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input bit gap_ok);
    int kind, al, at, aw, ah, bl, bt, bw, bh;
    kind = $urandom_range(0, 9);
    aw = $urandom_range(0, 600);
    ah = $urandom_range(0, 600);
    bw = $urandom_range(0, 600);
    bh = $urandom_range(0, 600);
    al = $urandom_range(0, COORD_MAX - aw);
    at = $urandom_range(0, COORD_MAX - ah);
    bl = al - bw + int'($urandom_range(0, aw + bw));
    bt = at - bh + int'($urandom_range(0, ah + bh));
    case (kind)
      6: begin
        al = $urandom_range(0, COORD_MAX); at = $urandom_range(0, COORD_MAX);
        aw = $urandom_range(0, COORD_MAX); ah = $urandom_range(0, COORD_MAX);
        bl = $urandom_range(0, COORD_MAX); bt = $urandom_range(0, COORD_MAX);
        bw = $urandom_range(0, COORD_MAX); bh = $urandom_range(0, COORD_MAX);
      end
      7: begin
        if ($urandom_range(0, 1)) bl = al + aw;
        else bt = at + ah;
      end
      8: begin
        al = $urandom_range(0, 600); at = $urandom_range(0, 600);
        bl = $urandom_range(0, 600); bt = $urandom_range(0, 600);
        aw = $urandom_range(COORD_MAX - 600, COORD_MAX);
        ah = $urandom_range(COORD_MAX - 600, COORD_MAX);
        bw = $urandom_range(COORD_MAX - 600, COORD_MAX);
        bh = $urandom_range(COORD_MAX - 600, COORD_MAX);
      end
      9: begin
        aw = $urandom_range(0, 3); ah = $urandom_range(0, 3);
        bw = $urandom_range(0, 3); bh = $urandom_range(0, 3);
        bl = al + int'($urandom_range(0, 4)) - 2;
        bt = at + int'($urandom_range(0, 4)) - 2;
      end
      default: ;
    endcase
    send_boxes(to_coord(al), to_coord(at), to_coord(aw), to_coord(ah),
               to_coord(bl), to_coord(bt), to_coord(bw), to_coord(bh), gap_ok);
  endtask

  initial begin : stimulus
    bit gap_ok;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, separation both ways, touching, containment, zero areas
    send_boxes(0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_boxes(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1);
    send_boxes(0, 0, 4095, 4095, 4095, 4095, 4095, 4095, 1);
    send_boxes(4095, 4095, 4095, 4095, 0, 0, 4095, 4095, 1);
    send_boxes(10, 20, 30, 40, 10, 20, 30, 40, 1);
    send_boxes(0, 0, 10, 10, 11, 0, 10, 10, 1);
    send_boxes(100, 0, 10, 10, 0, 0, 10, 10, 1);
    send_boxes(0, 0, 10, 10, 0, 11, 10, 10, 1);
    send_boxes(0, 100, 10, 10, 0, 0, 10, 10, 1);
    send_boxes(0, 0, 10, 10, 10, 0, 10, 10, 1);
    send_boxes(0, 0, 10, 10, 0, 10, 10, 10, 1);
    send_boxes(0, 0, 100, 100, 25, 25, 50, 50, 1);
    send_boxes(0, 0, 100, 100, 10, 10, 0, 50, 1);
    send_boxes(5, 5, 0, 0, 5, 5, 0, 0, 1);
    send_boxes(0, 0, 2, 1, 1, 0, 2, 1, 1);
    send_boxes(4095, 0, 0, 1, 0, 0, 4095, 1, 1);
    send_boxes(0, 0, 1, 1, 0, 0, 4095, 4095, 1);
    send_boxes(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 1);
    send_boxes(4095, 4095, 0, 0, 0, 0, 4095, 4095, 0);
    send_boxes(0, 4095, 4095, 0, 4095, 0, 0, 4095, 1);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_FROM) hold_request = 1'b1;
      if (n == N_RANDOM - CALM_ITEMS) calm = 1'b1;
      if (n == DRAIN_AT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      gap_ok = !(n >= HOLD_FROM && n < HOLD_FROM + HOLD_ITEMS);
      send_random(gap_ok);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 8) @(posedge clk_i);

    $display("Sent %0d box pairs (directed edge cases, then random overlapping, touching,",
             pairs_sent);
    $display("tiny and full-range pairs); %0d results checked, %0d flagged as no overlap.",
             checked, apart);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
